### rtl/core/bds_pkg.sv
// Shared constants, types and helper functions for the 3x3 box downscaler.
`timescale 1ns / 1ps

package bds_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int BLOCK_COLS = MAX_WIDTH / 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BX_W       = $clog2(BLOCK_COLS);
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 12;
  localparam int CFG_W      = 12;
  localparam int ROW_W      = 12;
  localparam int BY_W       = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(1080);
  localparam logic [CFG_W-1:0] WIDTH_CAP    = CFG_W'(MAX_WIDTH);

  // Phase of a pixel inside its block, along a row or along a column.
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] width_eff;
    logic [BX_W-1:0]  bx_limit;
    logic [CFG_W-1:0] height;
    logic [BY_W-1:0]  by_limit;
  } cfg_t;

  typedef struct packed {
    logic            in_block;
    logic            band_start;
    logic            block_end;
    logic [BX_W-1:0] bx;
    logic [BY_W-1:0] by;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  // floor(n / 3) for 12-bit n: multiply by ceil(2^13 / 3).
  function automatic logic [10:0] div3(input logic [11:0] n);
    logic [23:0] p;
    p = {12'd0, n} * 24'd2731;
    return p[23:13];
  endfunction

  // floor(n / 9) for 12-bit n: multiply by ceil(2^15 / 9).
  function automatic logic [8:0] div9(input logic [11:0] n);
    logic [23:0] p;
    p = {12'd0, n} * 24'd3641;
    return p[23:15];
  endfunction

endpackage

### rtl/core/bds_intf.sv
// Channel interfaces: input pixels, output block averages, configuration writes.
`timescale 1ns / 1ps

interface bds_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bds_pkg::PIX_W-1:0] pix_blue;
  logic [bds_pkg::PIX_W-1:0] pix_green;
  logic [bds_pkg::PIX_W-1:0] pix_red;

  modport source (output valid, pix_blue, pix_green, pix_red, input ready);
  modport sink (input valid, pix_blue, pix_green, pix_red, output ready);
endinterface

interface bds_avg_if;
  logic                      valid;
  logic                      ready;
  logic [bds_pkg::PIX_W-1:0] avg_blue;
  logic [bds_pkg::PIX_W-1:0] avg_green;
  logic [bds_pkg::PIX_W-1:0] avg_red;
  logic [bds_pkg::BX_W-1:0]  out_x;
  logic [bds_pkg::BY_W-1:0]  out_y;

  modport source (output valid, avg_blue, avg_green, avg_red, out_x, out_y, input ready);
  modport sink (input valid, avg_blue, avg_green, avg_red, out_x, out_y, output ready);
endinterface

interface bds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bds_pkg::CFG_IDX_W-1:0] index;
  logic [bds_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/box_downscale_3x3_rgb_core.sv
// Top level of the 3x3 box-filter downscaler for three-channel 8-bit pixels.
`timescale 1ns / 1ps

// Channels:
//   pix - input pixels in raster order, one item per accepted valid/ready beat.
//   avg - one item per complete 3x3 block: channel sums divided by nine
//         (truncated) plus the block column and row in the downscaled frame.
//   cfg - register writes; index 0 sets frame_width, index 1 frame_height.
//         Always ready; write only while no pixel is in flight.
// Throughput: one pixel per clock while avg is not stalled. The band sum RAM
// does one read and one write per cycle; a write that hits the entry read in
// the same cycle is forwarded, so back-to-back pixels of one block never wait.
// Result path: the edge that accepts a block's bottom-right pixel reads the RAM
// and loads the update stage; the result register loads when that stage advances.
// Reset: positions return to the frame origin and the registers to 1920 x
// 1080. Band sums are not cleared; the first row of each band writes them.
// Stall: while a result waits on avg.ready the update stage holds its pixel
// and pix.ready drops once that stage is occupied. Blocks cut off at the
// right or bottom edge give no result.
module box_downscale_3x3_rgb_core (
  input  logic      clk,
  input  logic      rst,
  bds_pix_if.sink   pix,
  bds_avg_if.source avg,
  bds_cfg_if.sink   cfg
);

  bds_pkg::cfg_t             cfg_q;
  bds_pkg::pos_t             pos;
  bds_pkg::pix_t             pixel;
  logic                      in_ready;
  logic                      in_accept;
  logic                      wr_en;
  logic [bds_pkg::BX_W-1:0]  wr_addr;
  bds_pkg::sums_t            wr_data;
  bds_pkg::sums_t            rd_data;

  assign pix.ready = in_ready;
  assign in_accept = pix.valid && in_ready;

  assign pixel.blue  = pix.pix_blue;
  assign pixel.green = pix.pix_green;
  assign pixel.red   = pix.pix_red;

  bds_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  // Advance the raster position once per accepted item.
  bds_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept),
    .cfg     (cfg_q),
    .pos     (pos)
  );

  // Per-block-column running sums of the current band; read on accept.
  bds_ram #(
    .WIDTH ($bits(bds_pkg::sums_t)),
    .DEPTH (bds_pkg::BLOCK_COLS)
  ) u_band_sums (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (pos.bx),
    .rdata (rd_data)
  );

  bds_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .pos       (pos),
    .pixel     (pixel),
    .in_ready  (in_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .avg       (avg)
  );

endmodule

### rtl/core/bds_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bds_cfg.sv
// Configuration registers with the derived block counts.
`timescale 1ns / 1ps

module bds_cfg (
  input  logic          clk,
  input  logic          rst,
  bds_cfg_if.sink       cfg,
  output bds_pkg::cfg_t cfg_q
);

  logic [bds_pkg::CFG_W-1:0] width_clip;

  assign cfg.ready = 1'b1;

  // Clip the width to the band sum capacity.
  assign width_clip = (cfg.data > bds_pkg::WIDTH_CAP) ? bds_pkg::WIDTH_CAP : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.width_eff <= bds_pkg::RESET_WIDTH;
      cfg_q.bx_limit  <= bds_pkg::BX_W'(bds_pkg::div3(bds_pkg::RESET_WIDTH));
      cfg_q.height    <= bds_pkg::RESET_HEIGHT;
      cfg_q.by_limit  <= bds_pkg::BY_W'(bds_pkg::div3(bds_pkg::RESET_HEIGHT));
    end else if (cfg.valid) begin
      if (cfg.index == bds_pkg::REG_FRAME_WIDTH) begin
        cfg_q.width_eff <= width_clip;
        cfg_q.bx_limit  <= bds_pkg::BX_W'(bds_pkg::div3(width_clip));
      end else if (cfg.index == bds_pkg::REG_FRAME_HEIGHT) begin
        cfg_q.height   <= cfg.data;
        cfg_q.by_limit <= bds_pkg::BY_W'(bds_pkg::div3(cfg.data));
      end
    end
  end

endmodule

### rtl/core/bds_pos.sv
// Raster position counters and block flags for the next pixel.
`timescale 1ns / 1ps

module bds_pos (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  bds_pkg::cfg_t cfg,
  output bds_pkg::pos_t pos
);

  logic [bds_pkg::COL_W-1:0] col;
  logic [1:0]                cx;
  logic [bds_pkg::BX_W-1:0]  bx;
  logic [bds_pkg::ROW_W-1:0] row;
  logic [1:0]                ry;
  logic [bds_pkg::BY_W-1:0]  by;

  logic [bds_pkg::CFG_W-1:0] col_inc;
  logic [bds_pkg::ROW_W:0]   row_inc;

  assign col_inc = bds_pkg::CFG_W'(col) + bds_pkg::CFG_W'(1);
  assign row_inc = {1'b0, row} + (bds_pkg::ROW_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      cx  <= bds_pkg::PHASE_FIRST;
      bx  <= '0;
      row <= '0;
      ry  <= bds_pkg::PHASE_FIRST;
      by  <= '0;
    end else if (advance) begin
      if (col_inc >= cfg.width_eff) begin
        col <= '0;
        cx  <= bds_pkg::PHASE_FIRST;
        bx  <= '0;
        if (row_inc >= {1'b0, cfg.height}) begin
          row <= '0;
          ry  <= bds_pkg::PHASE_FIRST;
          by  <= '0;
        end else begin
          row <= row_inc[bds_pkg::ROW_W-1:0];
          if (ry == bds_pkg::PHASE_LAST) begin
            ry <= bds_pkg::PHASE_FIRST;
            by <= by + bds_pkg::BY_W'(1);
          end else begin
            ry <= ry + 2'd1;
          end
        end
      end else begin
        col <= col_inc[bds_pkg::COL_W-1:0];
        if (cx == bds_pkg::PHASE_LAST) begin
          cx <= bds_pkg::PHASE_FIRST;
          bx <= bx + bds_pkg::BX_W'(1);
        end else begin
          cx <= cx + 2'd1;
        end
      end
    end
  end

  assign pos.in_block   = (bx < cfg.bx_limit) && (by < cfg.by_limit);
  assign pos.band_start = (ry == bds_pkg::PHASE_FIRST) && (cx == bds_pkg::PHASE_FIRST);
  assign pos.block_end  = (ry == bds_pkg::PHASE_LAST) && (cx == bds_pkg::PHASE_LAST);
  assign pos.bx         = bx;
  assign pos.by         = by;

endmodule

### rtl/core/bds_accum.sv
// Band sum update stage with write forwarding and the result register.
`timescale 1ns / 1ps

module bds_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_accept,
  input  bds_pkg::pos_t            pos,
  input  bds_pkg::pix_t            pixel,
  output logic                     in_ready,
  output logic                     wr_en,
  output logic [bds_pkg::BX_W-1:0] wr_addr,
  output bds_pkg::sums_t           wr_data,
  input  bds_pkg::sums_t           rd_data,
  bds_avg_if.source                avg
);

  logic           b_valid;
  bds_pkg::pos_t  b_pos;
  bds_pkg::pix_t  b_pix;
  logic           fwd;
  bds_pkg::sums_t fwd_data;

  logic           b_adv;
  bds_pkg::sums_t base;
  bds_pkg::sums_t sum_next;

  assign b_adv    = b_valid && (!avg.valid || avg.ready);
  assign in_ready = !b_valid || b_adv;

  always_comb begin
    if (b_pos.band_start) begin
      base = '0;
    end else if (fwd) begin
      base = fwd_data;
    end else begin
      base = rd_data;
    end
    sum_next.blue  = base.blue + bds_pkg::SUM_W'(b_pix.blue);
    sum_next.green = base.green + bds_pkg::SUM_W'(b_pix.green);
    sum_next.red   = base.red + bds_pkg::SUM_W'(b_pix.red);
  end

  assign wr_en   = b_adv && b_pos.in_block;
  assign wr_addr = b_pos.bx;
  assign wr_data = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  // Catch a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_pos    <= pos;
      b_pix    <= pixel;
      fwd      <= wr_en && (b_pos.bx == pos.bx);
      fwd_data <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg.valid <= 1'b0;
    end else if (b_adv && b_pos.in_block && b_pos.block_end) begin
      avg.valid <= 1'b1;
    end else if (avg.ready) begin
      avg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_pos.in_block && b_pos.block_end) begin
      avg.avg_blue  <= bds_pkg::PIX_W'(bds_pkg::div9(sum_next.blue));
      avg.avg_green <= bds_pkg::PIX_W'(bds_pkg::div9(sum_next.green));
      avg.avg_red   <= bds_pkg::PIX_W'(bds_pkg::div9(sum_next.red));
      avg.out_x     <= b_pos.bx;
      avg.out_y     <= b_pos.by;
    end
  end

endmodule
